FILE: hw/rtl/afsa_pkg.sv
package afsa_pkg;

    // request codes
    localparam logic [1:0] REQ_FOCUS       = 2'd0;
    localparam logic [1:0] REQ_ABANDON     = 2'd1;
    localparam logic [1:0] REQ_ABANDON_ALL = 2'd2;
    localparam logic [1:0] REQ_SET_SYS     = 2'd3;

    // hint and event codes
    localparam logic [2:0] HINT_GAIN         = 3'd0;
    localparam logic [2:0] HINT_TRANSIENT    = 3'd1;
    localparam logic [2:0] HINT_MAY_DUCK     = 3'd2;
    localparam logic [2:0] HINT_EXCLUSIVE    = 3'd3;
    localparam logic [2:0] EV_LOSS           = 3'd4;
    localparam logic [2:0] EV_LOSS_TRANSIENT = 3'd5;
    localparam logic [2:0] EV_LOSS_CAN_DUCK  = 3'd6;

    // status codes
    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_BAD_HINT = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] FULL_LEVEL = 2'd3;
    localparam logic [1:0] DUCK_NEED  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear_all;
        logic idx_clr;
        logic find_next;
        logic reject;
        logic move;
        logic remove;
        logic disp_step;
        logic emit_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req;
        logic       hint_bad;
        logic       find_end;
        logic       find_hit;
        logic       full;
        logic       rm_disp;
        logic       set_disp;
        logic       out_free;
        logic       disp_end;
        logic       disp_brk;
    } t_stat;

endpackage

FILE: hw/rtl/afsa_ctrl.sv
module afsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  afsa_pkg::t_stat i_stat,
    output afsa_pkg::t_cmd  o_cmd
);
    import afsa_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DECODE, S_FIND, S_DISP, S_STATUS} t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    // decide commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.req)
                    REQ_FOCUS: begin
                        if (i_stat.hint_bad) begin
                            n_state = S_STATUS;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_FIND;
                        end
                    end
                    REQ_ABANDON: begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_FIND;
                    end
                    REQ_ABANDON_ALL: begin
                        o_cmd.clear_all = 1'b1;
                        n_state         = S_STATUS;
                    end
                    default: begin
                        if (i_stat.set_disp) begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_DISP;
                        end else begin
                            n_state = S_STATUS;
                        end
                    end
                endcase
            end
            S_FIND: begin
                priority if (i_stat.find_end) begin
                    if (i_stat.req == REQ_FOCUS) begin
                        if (i_stat.full) begin
                            o_cmd.reject = 1'b1;
                            n_state      = S_STATUS;
                        end else begin
                            o_cmd.move    = 1'b1;
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_DISP;
                        end
                    end else begin
                        n_state = S_STATUS;
                    end
                end else if (i_stat.find_hit) begin
                    if (i_stat.req == REQ_FOCUS) begin
                        o_cmd.move    = 1'b1;
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_DISP;
                    end else begin
                        o_cmd.remove = 1'b1;
                        if (i_stat.rm_disp) begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_DISP;
                        end else begin
                            n_state = S_STATUS;
                        end
                    end
                end else begin
                    o_cmd.find_next = 1'b1;
                end
            end
            S_DISP: begin
                if (i_stat.disp_end) begin
                    n_state = S_STATUS;
                end else if (i_stat.out_free) begin
                    o_cmd.disp_step = 1'b1;
                    if (i_stat.disp_brk) n_state = S_STATUS;
                end
            end
            default: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state           = S_IDLE;
                end
            end
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/afsa_dp.sv
module afsa_dp #(
    parameter int STACK_DEPTH = 8,
    parameter int COOKIE_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  afsa_pkg::t_cmd  i_cmd,
    output afsa_pkg::t_stat o_stat,
    input  logic [1:0]      i_req_type,
    input  logic [15:0]     i_cookie,
    input  logic [2:0]      i_hint,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_kind,
    output logic [1:0]      o_status,
    output logic [15:0]     o_target_cookie,
    output logic [2:0]      o_focus_event,
    output logic            o_last_result
);
    import afsa_pkg::*;

    localparam int CNTW = $clog2(STACK_DEPTH + 1);
    localparam int IW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW   = $clog2(3 * STACK_DEPTH + 1);

    // holder stack, index 0 is the top
    logic [COOKIE_BITS-1:0] r_ck  [STACK_DEPTH];
    logic [1:0]             r_hn  [STACK_DEPTH];
    logic [1:0]             r_cur [STACK_DEPTH];
    logic [COOKIE_BITS-1:0] n_ck  [STACK_DEPTH];
    logic [1:0]             n_hn  [STACK_DEPTH];
    logic [1:0]             n_cur [STACK_DEPTH];

    logic [CNTW-1:0]        r_cnt, n_cnt;
    logic [1:0]             r_sys;
    logic                   r_trans;
    logic [1:0]             r_req;
    logic [COOKIE_BITS-1:0] r_cookie;
    logic [2:0]             r_hint;
    logic                   r_rej;
    logic [CNTW-1:0]        r_i;
    logic [FW-1:0]          r_found;
    logic [1:0]             r_rem;

    logic                   r_ovalid;
    logic                   r_okind;
    logic [1:0]             r_ostatus;
    logic [15:0]            r_ocookie;
    logic [2:0]             r_oevent;
    logic                   r_olast;

    logic [IW-1:0]          idx;
    logic [1:0]             lvl;
    logic                   tr;
    logic [1:0]             need, c, nrem;
    logic                   recov, changed, rm;
    logic [FW-1:0]          nfound;
    logic [2:0]             ev;
    logic                   out_free;
    logic [1:0]             stat_code;

    assign idx      = r_i[IW-1:0];
    assign out_free = !r_ovalid || i_ready;

    // map the system focus request to a level and transitivity
    always_comb begin
        tr = 1'b1;
        unique case (r_hint)
            HINT_GAIN, HINT_TRANSIENT: lvl = FULL_LEVEL;
            HINT_EXCLUSIVE: begin
                lvl = FULL_LEVEL;
                if (r_sys == 2'd0) tr = 1'b0;
            end
            HINT_MAY_DUCK:    lvl = DUCK_NEED;
            EV_LOSS_CAN_DUCK: lvl = 2'd1;
            default:          lvl = 2'd0;
        endcase
    end

    // one dispatch step at the walk index
    always_comb begin
        need    = (r_hn[idx] == HINT_MAY_DUCK[1:0]) ? DUCK_NEED : FULL_LEVEL;
        recov   = (r_hn[idx] == HINT_GAIN[1:0]);
        c       = (need < r_rem) ? need : r_rem;
        nrem    = r_rem - c;
        nfound  = r_found + FW'(r_cur[idx]);
        changed = (c != r_cur[idx]);
        rm      = changed && (c == 2'd0) && !recov;
        priority if (c == need) ev = {1'b0, r_hn[idx]};
        else if (c == 2'd0)     ev = recov ? EV_LOSS_TRANSIENT : EV_LOSS;
        else                    ev = EV_LOSS_CAN_DUCK;
    end

    assign stat_code = (r_req == REQ_FOCUS && r_hint[2]) ? ST_BAD_HINT :
                       (r_rej ? ST_FULL : ST_GRANTED);

    // status toward the controller
    always_comb begin
        o_stat.req      = r_req;
        o_stat.hint_bad = r_hint[2];
        o_stat.find_end = (r_i >= r_cnt);
        o_stat.find_hit = (r_i < r_cnt) && (r_ck[idx] == r_cookie);
        o_stat.full     = (r_cnt == CNTW'(STACK_DEPTH));
        o_stat.rm_disp  = r_trans && (r_cnt > CNTW'(1));
        o_stat.set_disp = ((lvl != r_sys) || (tr != r_trans)) && (r_cnt != '0);
        o_stat.out_free = out_free;
        o_stat.disp_end = (r_i >= r_cnt);
        o_stat.disp_brk = (nfound == FW'(r_sys)) && (nrem == 2'd0);
    end

    // next stack contents: insert at top, remove at index, update share
    always_comb begin
        n_ck  = r_ck;
        n_hn  = r_hn;
        n_cur = r_cur;
        n_cnt = r_cnt;
        if (i_cmd.clear_all) n_cnt = '0;
        if (i_cmd.move) begin
            for (int k = 0; k < STACK_DEPTH; k++) begin
                if (k == 0) begin
                    n_ck[k]  = r_cookie;
                    n_hn[k]  = r_hint[1:0];
                    n_cur[k] = 2'd0;
                end else if (CNTW'(k) <= r_i) begin
                    n_ck[k]  = r_ck[k-1];
                    n_hn[k]  = r_hn[k-1];
                    n_cur[k] = r_cur[k-1];
                end
            end
            if (!o_stat.find_hit) n_cnt = r_cnt + 1'b1;
        end
        if (i_cmd.remove || (i_cmd.disp_step && rm)) begin
            for (int k = 0; k < STACK_DEPTH - 1; k++) begin
                if (CNTW'(k) >= r_i) begin
                    n_ck[k]  = r_ck[k+1];
                    n_hn[k]  = r_hn[k+1];
                    n_cur[k] = r_cur[k+1];
                end
            end
            n_cnt = r_cnt - 1'b1;
        end else if (i_cmd.disp_step) begin
            n_cur[idx] = c;
        end
    end

    // stack payload
    always_ff @(posedge i_clk) begin
        r_ck  <= n_ck;
        r_hn  <= n_hn;
        r_cur <= n_cur;
    end

    // control state and walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_sys   <= FULL_LEVEL;
            r_trans <= 1'b1;
            r_rej   <= 1'b0;
            r_i     <= '0;
            r_found <= '0;
            r_rem   <= '0;
            r_req   <= REQ_FOCUS;
            r_hint  <= HINT_GAIN;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.load) begin
                r_req    <= i_req_type;
                r_cookie <= COOKIE_BITS'(i_cookie);
                r_hint   <= i_hint;
                r_rej    <= 1'b0;
            end
            if (i_cmd.reject) r_rej <= 1'b1;
            if (i_cmd.idx_clr) begin
                r_i     <= '0;
                r_found <= '0;
                r_rem   <= (r_req == REQ_SET_SYS) ? lvl : r_sys;
            end else if (i_cmd.find_next) begin
                r_i <= r_i + 1'b1;
            end else if (i_cmd.disp_step) begin
                r_found <= nfound;
                r_rem   <= nrem;
                if (!rm) r_i <= r_i + 1'b1;
            end
            if (i_cmd.emit_status && r_req == REQ_SET_SYS) begin
                r_sys   <= lvl;
                r_trans <= tr;
            end
        end
    end

    // output register: load a notification or the closing status beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_status) begin
            r_ovalid <= 1'b1;
        end else if (i_cmd.disp_step && changed) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_status) begin
            r_okind   <= 1'b0;
            r_ostatus <= stat_code;
            r_ocookie <= 16'(r_cookie);
            r_oevent  <= HINT_GAIN;
            r_olast   <= 1'b1;
        end else if (i_cmd.disp_step && changed) begin
            r_okind   <= 1'b1;
            r_ostatus <= ST_GRANTED;
            r_ocookie <= 16'(r_ck[idx]);
            r_oevent  <= ev;
            r_olast   <= 1'b0;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_kind          = r_okind;
    assign o_status        = r_ostatus;
    assign o_target_cookie = r_ocookie;
    assign o_focus_event   = r_oevent;
    assign o_last_result   = r_olast;

endmodule

FILE: hw/rtl/audio_focus_stack_arbiter_core.sv
// Audio focus stack arbiter. One request is taken at a time; o_ready is high
// only while the block is idle. A request passes through the idle state that
// accepts it, a decode step, a serial search of the holders up to and including
// the match, a top-down focus walk that stops early or at the end of the stack,
// and the status beat; search and walk run over the stack registers, and only
// where the request needs them. Each result beat waits in a single output
// register; while it is not taken the walk holds. Notifications come first in
// stack order, the status beat always closes the request with o_last_result set.
module audio_focus_stack_arbiter_core #(
    parameter int STACK_DEPTH = 8,
    parameter int COOKIE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_cookie,
    input  logic [2:0]  i_hint,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [1:0]  o_status,
    output logic [15:0] o_target_cookie,
    output logic [2:0]  o_focus_event,
    output logic        o_last_result
);
    import afsa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    afsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    afsa_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .COOKIE_BITS (COOKIE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_type      (i_req_type),
        .i_cookie        (i_cookie),
        .i_hint          (i_hint),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_status        (o_status),
        .o_target_cookie (o_target_cookie),
        .o_focus_event   (o_focus_event),
        .o_last_result   (o_last_result)
    );

endmodule

FILE: hw/rtl/afsa_chk.sv
module afsa_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_kind,
    input logic [1:0]  o_status,
    input logic [15:0] o_target_cookie,
    input logic [2:0]  o_focus_event,
    input logic        o_last_result
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_status)
        && $stable(o_target_cookie) && $stable(o_focus_event)
        && $stable(o_last_result))
        else $error("result beat changed while stalled");

    // take no new request right after one is accepted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted while busy");

    // close every request with the status beat alone
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_result == !o_kind))
        else $error("last marker not on status beat");

    // notify with a granted status field only
    a_notify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_status == 2'd0)
        else $error("notification carries status");

endmodule

bind audio_focus_stack_arbiter_core afsa_chk u_afsa_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_kind          (o_kind),
    .o_status        (o_status),
    .o_target_cookie (o_target_cookie),
    .o_focus_event   (o_focus_event),
    .o_last_result   (o_last_result)
);

FILE: tb/audio_focus_stack_arbiter_core_tb.sv
`timescale 1ns / 1ps

module audio_focus_stack_arbiter_core_tb;
    import afsa_pkg::*;

    localparam int DEPTH = 8;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [15:0] cookie;
        logic [2:0]  event_code;
        logic        last;
    } t_focus_beat;

    typedef struct {
        logic [15:0] cookie;
        logic [2:0]  hint;
        logic [1:0]  need;
        logic [1:0]  share;
        logic        recoverable;
    } t_holder;

    // Shadow of the focus stack; predicts the beats each request causes
    class focus_scoreboard;
        t_holder     stack[DEPTH];
        int          count;
        logic [1:0]  level;
        logic        transitive;
        t_focus_beat pending[$];
        int          errors;

        function void clear();
            count = 0;
            level = FULL_LEVEL;
            transitive = 1'b1;
            pending.delete();
            errors = 0;
        endfunction

        function void push_beat(logic kind, logic [1:0] st, logic [15:0] ck,
                                logic [2:0] ev);
            t_focus_beat b;
            b.kind = kind;
            b.status = st;
            b.cookie = ck;
            b.event_code = ev;
            b.last = 1'b0;
            pending.push_back(b);
        endfunction

        function void drop_at(int idx);
            for (int k = idx; k + 1 < count; k++) stack[k] = stack[k + 1];
            count--;
        endfunction

        function int lookup(logic [15:0] ck);
            for (int i = 0; i < count; i++) if (stack[i].cookie == ck) return i;
            return -1;
        endfunction

        // Hand out the level top-down and notify every changed share
        function void share_out(int total);
            int remaining, found, i, grant, prev;
            bit gone;
            remaining = total;
            found = 0;
            i = 0;
            while (i < count) begin
                prev = stack[i].share;
                grant = (stack[i].need < remaining) ? stack[i].need : remaining;
                stack[i].share = 2'(grant);
                found += prev;
                remaining -= grant;
                gone = 0;
                if (grant != prev) begin
                    if (grant == stack[i].need) begin
                        push_beat(1'b1, ST_GRANTED, stack[i].cookie, stack[i].hint);
                    end else if (grant == 0) begin
                        push_beat(1'b1, ST_GRANTED, stack[i].cookie,
                                  stack[i].recoverable ? EV_LOSS_TRANSIENT : EV_LOSS);
                        if (!stack[i].recoverable) begin
                            drop_at(i);
                            gone = 1;
                        end
                    end else begin
                        push_beat(1'b1, ST_GRANTED, stack[i].cookie, EV_LOSS_CAN_DUCK);
                    end
                end
                if (!gone) i++;
                if (found == level && remaining == 0) break;
            end
        endfunction

        function void note_request(logic [1:0] req, logic [15:0] ck, logic [2:0] hint);
            logic [1:0] st;
            int j, top, lvl;
            logic tr;
            st = ST_GRANTED;
            case (req)
                REQ_FOCUS: begin
                    if (hint > HINT_EXCLUSIVE) begin
                        st = ST_BAD_HINT;
                    end else begin
                        j = lookup(ck);
                        if (j < 0 && count >= DEPTH) begin
                            st = ST_FULL;
                        end else begin
                            top = (j < 0) ? count : j;
                            for (int k = top; k > 0; k--) stack[k] = stack[k - 1];
                            if (j < 0) count++;
                            stack[0].cookie = ck;
                            stack[0].hint = hint;
                            stack[0].need = (hint == HINT_MAY_DUCK) ? DUCK_NEED : FULL_LEVEL;
                            stack[0].share = 2'd0;
                            stack[0].recoverable = (hint == HINT_GAIN);
                            share_out(level);
                        end
                    end
                end
                REQ_ABANDON: begin
                    j = lookup(ck);
                    if (j >= 0) begin
                        drop_at(j);
                        if (transitive && count > 0) share_out(level);
                    end
                end
                REQ_ABANDON_ALL: begin
                    count = 0;
                end
                default: begin
                    tr = 1'b1;
                    case (hint)
                        HINT_GAIN, HINT_TRANSIENT: lvl = 3;
                        HINT_EXCLUSIVE: begin
                            lvl = 3;
                            if (level == 0) tr = 1'b0;
                        end
                        HINT_MAY_DUCK: lvl = 2;
                        EV_LOSS_CAN_DUCK: lvl = 1;
                        default: lvl = 0;
                    endcase
                    if (level != lvl || transitive != tr) begin
                        if (count > 0) share_out(lvl);
                        level = 2'(lvl);
                        transitive = tr;
                    end
                end
            endcase
            push_beat(1'b0, st, ck, 3'd0);
            pending[pending.size() - 1].last = 1'b1;
        endfunction

        task check_beat(t_focus_beat got);
            t_focus_beat want;
            if (pending.size() == 0) begin
                report_mismatch("beat with nothing expected", 0, got);
                return;
            end
            want = pending.pop_front();
            if (got.kind != want.kind) report_mismatch("kind", want, got);
            if (got.status != want.status) report_mismatch("status", want, got);
            if (got.cookie != want.cookie) report_mismatch("target_cookie", want, got);
            if (got.event_code != want.event_code)
                report_mismatch("focus_event", want, got);
            if (got.last != want.last) report_mismatch("last_result", want, got);
        endtask

        task report_mismatch(string what, t_focus_beat want, t_focus_beat got);
            $display("mismatch %s: want %h got %h", what, want, got);
            errors++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_req_type;
    logic [15:0] i_cookie;
    logic [2:0]  i_hint;
    logic        o_valid;
    logic        i_ready;
    logic        o_kind;
    logic [1:0]  o_status;
    logic [15:0] o_target_cookie;
    logic [2:0]  o_focus_event;
    logic        o_last_result;

    focus_scoreboard sb;
    bit   calm_phase;
    bit   hold_off;
    int   idle_cycles = 0;
    logic [15:0] cookie_pool[6];

    audio_focus_stack_arbiter_core DUT (.*);

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Score both channels on each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_request(i_req_type, i_cookie, i_hint);
            if (o_valid && i_ready)
                sb.check_beat({o_kind, o_status, o_target_cookie, o_focus_event,
                               o_last_result});
        end
    end

    // Watchdog: count cycles with no beat accepted
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off, none at the end
    initial begin
        int gap;
        bit held;
        held = 0;
        i_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off && !held) begin
                i_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                held = 1;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 5);
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one request; valid stays high into the next request unless a gap follows
    task automatic send_request(logic [1:0] req, logic [15:0] ck, logic [2:0] hint);
        int gap;
        if (!calm_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_cookie <= ck;
        i_hint <= hint;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic random_request();
        int roll;
        logic [15:0] ck;
        roll = $urandom_range(0, 99);
        ck = ($urandom_range(0, 9) == 0) ? 16'($urandom) : cookie_pool[$urandom_range(0, 5)];
        if (roll < 55) send_request(REQ_FOCUS, ck, 3'($urandom_range(0, 3)));
        else if (roll < 62) send_request(REQ_FOCUS, ck, 3'($urandom_range(4, 7)));
        else if (roll < 80) send_request(REQ_ABANDON, ck, 3'($urandom));
        else if (roll < 84) send_request(REQ_ABANDON_ALL, ck, 3'($urandom));
        else send_request(REQ_SET_SYS, ck, 3'($urandom));
    endtask

    initial begin
        sb = new();
        sb.clear();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req_type <= REQ_FOCUS;
        i_cookie <= '0;
        i_hint <= HINT_GAIN;
        calm_phase = 0;
        hold_off = 0;
        cookie_pool = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'h0001, 16'h8000};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: hints, bad hint, full stack, abandons, system level changes
        send_request(REQ_FOCUS, 16'h0000, HINT_GAIN);
        send_request(REQ_FOCUS, 16'hFFFF, HINT_MAY_DUCK);
        send_request(REQ_FOCUS, 16'h1234, HINT_TRANSIENT);
        send_request(REQ_FOCUS, 16'h4321, HINT_EXCLUSIVE);
        send_request(REQ_FOCUS, 16'h0000, 3'd7);
        send_request(REQ_FOCUS, 16'h0000, EV_LOSS);
        send_request(REQ_ABANDON, 16'h7777, HINT_GAIN);
        send_request(REQ_ABANDON, 16'h4321, HINT_GAIN);
        send_request(REQ_SET_SYS, 16'h0000, EV_LOSS_CAN_DUCK);
        send_request(REQ_SET_SYS, 16'h0000, HINT_MAY_DUCK);
        send_request(REQ_SET_SYS, 16'h0000, EV_LOSS);
        send_request(REQ_SET_SYS, 16'h0000, HINT_EXCLUSIVE);
        send_request(REQ_ABANDON, 16'hFFFF, HINT_GAIN);
        send_request(REQ_SET_SYS, 16'hFFFF, HINT_GAIN);
        for (int i = 0; i < 9; i++) send_request(REQ_FOCUS, 16'(i * 16'h1111), HINT_GAIN);
        send_request(REQ_FOCUS, 16'h2222, HINT_MAY_DUCK);
        send_request(REQ_ABANDON_ALL, 16'hFFFF, 3'd7);

        // Long receiver hold-off while requests keep coming
        hold_off = 1;
        for (int i = 0; i < 6; i++) random_request();

        for (int i = 0; i < 70; i++) begin
            if (i == 56) calm_phase = 1;
            random_request();
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
